@@ rtl/core/mdbp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdbp_pkg: shared types and constants of the min-degree batch pair pool
// Entry status codes, request kinds, result codes and the pool size default.
// ----------------------------------------------------------------------------
package mdbp_pkg;

    localparam int DEF_POOL_DEPTH = 256;

    localparam int DEG_W   = 16;
    localparam int HND_W   = 16;
    localparam int LIM_W   = 9;
    localparam int STAMP_W = 32;

    typedef enum logic [1:0] {
        ST_FREE  = 2'd0,
        ST_POOL  = 2'd1,
        ST_BATCH = 2'd2
    } ent_status_t;

    typedef enum logic [1:0] {
        KIND_INSERT  = 2'd0,
        KIND_PREPARE = 2'd1,
        KIND_TAKE    = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        RES_OK    = 2'd0,
        RES_EMPTY = 2'd1,
        RES_FULL  = 2'd2
    } res_t;

    // sequencer states of the top level
    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } seq_state_t;

    // operation broadcast to every cell for one pass
    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_DISCARD,
        OP_SCAN_MIN,
        OP_MARK,
        OP_TAKE_FIND,
        OP_TAKE_FREE
    } cell_op_t;

    // token carried from cell to cell
    typedef struct packed {
        logic               found;   // a candidate has been seen
        logic [DEG_W-1:0]   degree;
        logic [HND_W-1:0]   handle;
        logic [STAMP_W-1:0] age;
        logic [12:0]        count;   // wide enough for any depth in range
        logic [12:0]        index;
        logic               done;    // insert or mark already applied
    } token_t;

    typedef struct packed {
        cell_op_t           op;
        logic [DEG_W-1:0]   degree;
        logic [HND_W-1:0]   handle;
        logic [STAMP_W-1:0] seq;
        logic [12:0]        cap;
        logic [12:0]        target;
    } cell_cmd_t;

endpackage

@@ rtl/core/mdbp_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdbp_cell: one slot of the pair pool
// Holds one pair and updates the token passing through it per operation.
// ----------------------------------------------------------------------------
module mdbp_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic [12:0]        my_index,
    input  mdbp_pkg::cell_cmd_t cmd,
    input  mdbp_pkg::token_t   tok_in,
    output mdbp_pkg::token_t   tok_out
);
    import mdbp_pkg::*;

    ent_status_t        status_reg, status_next;
    logic [DEG_W-1:0]   degree_reg, degree_next;
    logic [HND_W-1:0]   handle_reg, handle_next;
    logic [STAMP_W-1:0] stamp_reg, stamp_next;
    logic [STAMP_W-1:0] age;

    assign age = cmd.seq - stamp_reg;

    // token update and slot update
    always_comb begin
        tok_out     = tok_in;
        status_next = status_reg;
        degree_next = degree_reg;
        handle_next = handle_reg;
        stamp_next  = stamp_reg;
        case (cmd.op)
            OP_INSERT: begin
                if (!tok_in.done && status_reg == ST_FREE) begin
                    tok_out.done = 1'b1;
                    status_next  = ST_POOL;
                    degree_next  = cmd.degree;
                    handle_next  = cmd.handle;
                    stamp_next   = cmd.seq;
                end
            end
            OP_DISCARD: begin
                if (status_reg == ST_BATCH) status_next = ST_FREE;
            end
            OP_SCAN_MIN: begin
                if (status_reg == ST_POOL) begin
                    if (!tok_in.found || degree_reg < tok_in.degree) begin
                        tok_out.found  = 1'b1;
                        tok_out.degree = degree_reg;
                        tok_out.count  = 13'd1;
                    end else if (degree_reg == tok_in.degree) begin
                        tok_out.count = tok_in.count + 13'd1;
                    end
                end
            end
            OP_MARK: begin
                // the target found by the previous pass is marked, the other
                // entries of the degree look for the next newest one
                if (status_reg == ST_POOL && degree_reg == cmd.degree
                        && !tok_in.done && my_index == cmd.target) begin
                    status_next  = ST_BATCH;
                    tok_out.done = 1'b1;
                end else if (status_reg == ST_POOL && degree_reg == cmd.degree) begin
                    // search newest unmarked entry of the degree
                    if (!tok_in.found || age < tok_in.age) begin
                        tok_out.found = 1'b1;
                        tok_out.age   = age;
                        tok_out.index = my_index;
                    end
                end
            end
            OP_TAKE_FIND: begin
                // on equal ages the higher index counts as older
                if (status_reg == ST_BATCH) begin
                    if (!tok_in.found || age >= tok_in.age) begin
                        tok_out.found  = 1'b1;
                        tok_out.age    = age;
                        tok_out.index  = my_index;
                        tok_out.degree = degree_reg;
                        tok_out.handle = handle_reg;
                    end
                end
            end
            OP_TAKE_FREE: begin
                if (my_index == cmd.target) status_next = ST_FREE;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg <= ST_FREE;
        end else if (en) begin
            status_reg <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            degree_reg <= degree_next;
            handle_reg <= handle_next;
            stamp_reg  <= stamp_next;
        end
    end

endmodule

@@ rtl/core/min_degree_batch_pair_pool_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_degree_batch_pair_pool_core: min-degree batch pair pool
// Pool of degree/handle pairs with batched extraction of the lowest degree.
// ----------------------------------------------------------------------------
// The pool is a chain of POOL_DEPTH cells; each request walks a token through
// the chain one cell per cycle; one pass visits every cell in turn. Insert
// takes one pass. Take takes two passes (find the oldest batch pair, then free
// it), or one when the batch is empty. Prepare takes one discard pass, one
// minimum/count pass, one search pass and then one pass for every pair moved
// into the batch, so 3 + count passes in all; on an empty pool it ends
// after the first two passes. An unused kind takes no pass. The done state
// then loads the output register once it is free and returns to idle.
// One item is worked on at a time; a result waiting in the output register
// does not keep the next item from being accepted and worked on.
module min_degree_batch_pair_pool_core #(
    parameter int POOL_DEPTH = mdbp_pkg::DEF_POOL_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // pair_degree[15:0], pair_handle[31:16], batch_limit[40:32]
    input  logic [1:0]  s_tuser,  // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,  // batch_degree[15:0], pair_count[24:16], out_handle[40:25]
    output logic [1:0]  m_tuser   // status
);
    import mdbp_pkg::*;

    localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;

    seq_state_t  state_reg, state_next;
    cell_cmd_t   cmd_reg, cmd_next;
    logic [IW-1:0] pos_reg, pos_next;
    token_t      tok_reg, tok_next;
    logic [8:0]  limit_reg, limit_next;
    logic [12:0] moved_reg, moved_next;
    logic [12:0] want_reg, want_next;
    logic [STAMP_W-1:0] seq_reg, seq_next;
    logic [1:0]  res_status_reg, res_status_next;
    logic [15:0] res_deg_reg, res_deg_next;
    logic [8:0]  res_cnt_reg, res_cnt_next;
    logic [15:0] res_hnd_reg, res_hnd_next;
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_status_reg, out_status_next;
    logic [15:0] out_deg_reg, out_deg_next;
    logic [8:0]  out_cnt_reg, out_cnt_next;
    logic [15:0] out_hnd_reg, out_hnd_next;

    token_t tok_out [POOL_DEPTH];
    token_t cell_tok;
    logic   pass_end;

    // only the cell at the token position steps each cycle
    genvar g;
    generate
        for (g = 0; g < POOL_DEPTH; g++) begin : g_cell
            mdbp_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .en       (state_reg == S_RUN && pos_reg == IW'(g)),
                .my_index (13'(g)),
                .cmd      (cmd_reg),
                .tok_in   (tok_reg),
                .tok_out  (tok_out[g])
            );
        end
    endgenerate

    assign cell_tok = tok_out[pos_reg];
    assign pass_end = (pos_reg == IW'(POOL_DEPTH - 1));
    assign s_tready = (state_reg == S_IDLE);

    // sequencer
    always_comb begin
        token_t clr;
        logic [12:0] cnt;
        clr            = '0;
        cnt            = '0;
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        pos_next       = pos_reg;
        tok_next       = tok_reg;
        limit_next     = limit_reg;
        moved_next     = moved_reg;
        want_next      = want_reg;
        seq_next       = seq_reg;
        res_status_next = res_status_reg;
        res_deg_next   = res_deg_reg;
        res_cnt_next   = res_cnt_reg;
        res_hnd_next   = res_hnd_reg;
        out_valid_next = out_valid_reg;
        out_status_next = out_status_reg;
        out_deg_next   = out_deg_reg;
        out_cnt_next   = out_cnt_reg;
        out_hnd_next   = out_hnd_reg;
        if (out_valid_reg && m_tready) out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    limit_next    = s_tdata[40:32];
                    tok_next      = clr;
                    pos_next      = '0;
                    cmd_next      = '0;
                    cmd_next.degree = s_tdata[15:0];
                    cmd_next.handle = s_tdata[31:16];
                    cmd_next.seq  = seq_reg;
                    moved_next    = '0;
                    res_status_next = RES_EMPTY;
                    res_deg_next  = '0;
                    res_cnt_next  = '0;
                    res_hnd_next  = '0;
                    state_next    = S_RUN;
                    case (kind_t'(s_tuser))
                        KIND_INSERT:  cmd_next.op = OP_INSERT;
                        KIND_PREPARE: cmd_next.op = OP_DISCARD;
                        KIND_TAKE:    cmd_next.op = OP_TAKE_FIND;
                        default:      state_next = S_DONE;
                    endcase
                end
            end
            S_RUN: begin
                tok_next = cell_tok;
                pos_next = pos_reg + 1'b1;
                if (pass_end) begin
                    pos_next = '0;
                    tok_next = clr;
                    case (cmd_reg.op)
                        OP_INSERT: begin
                            if (cell_tok.done) begin
                                res_status_next = RES_OK;
                                seq_next = seq_reg + 1'b1;
                            end else begin
                                res_status_next = RES_FULL;
                            end
                            state_next = S_DONE;
                        end
                        OP_DISCARD: cmd_next.op = OP_SCAN_MIN;
                        OP_SCAN_MIN: begin
                            if (!cell_tok.found) begin
                                state_next = S_DONE;
                            end else begin
                                cnt = cell_tok.count;
                                if (limit_reg != '0 && 13'(limit_reg) < cnt)
                                    cnt = 13'(limit_reg);
                                want_next       = cnt;
                                cmd_next.op     = OP_MARK;
                                cmd_next.degree = cell_tok.degree;
                                cmd_next.target = {13{1'b1}};
                                res_status_next = RES_OK;
                                res_deg_next    = cell_tok.degree;
                                res_cnt_next    = (cnt > 13'd511) ? 9'd511 : cnt[8:0];
                            end
                        end
                        OP_MARK: begin
                            // each pass marks the newest found by the previous one
                            if (cmd_reg.target != {13{1'b1}})
                                moved_next = moved_reg + 1'b1;
                            if ((cmd_reg.target != {13{1'b1}} &&
                                 moved_reg + 13'd1 >= want_reg) || !cell_tok.found) begin
                                state_next = S_DONE;
                            end else begin
                                cmd_next.target = cell_tok.index;
                            end
                        end
                        OP_TAKE_FIND: begin
                            if (!cell_tok.found) begin
                                state_next = S_DONE;
                            end else begin
                                res_status_next = RES_OK;
                                res_deg_next    = cell_tok.degree;
                                res_hnd_next    = cell_tok.handle;
                                cmd_next.op     = OP_TAKE_FREE;
                                cmd_next.target = cell_tok.index;
                            end
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_DONE: begin
                // load the output register once it is free
                if (!out_valid_reg || m_tready) begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_deg_next    = res_deg_reg;
                    out_cnt_next    = res_cnt_reg;
                    out_hnd_next    = res_hnd_reg;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            seq_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            seq_reg       <= seq_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        pos_reg        <= pos_next;
        tok_reg        <= tok_next;
        limit_reg      <= limit_next;
        moved_reg      <= moved_next;
        want_reg       <= want_next;
        res_status_reg <= res_status_next;
        res_deg_reg    <= res_deg_next;
        res_cnt_reg    <= res_cnt_next;
        res_hnd_reg    <= res_hnd_next;
        out_status_reg <= out_status_next;
        out_deg_reg    <= out_deg_next;
        out_cnt_reg    <= out_cnt_next;
        out_hnd_reg    <= out_hnd_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {7'd0, out_hnd_reg, out_cnt_reg, out_deg_reg};

    // no new item while one is in flight
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_IDLE |-> !s_tready)
        else $error("ready while busy");
    // a held result stays until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");
    // sequence advances only on a successful insert
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_reg != $past(seq_reg) |-> $past(cmd_reg.op) == OP_INSERT)
        else $error("sequence moved");

endmodule

@@ tb/sv/min_degree_batch_pair_pool_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_degree_batch_pair_pool_core_tb: self-checking bench of the pair pool
// Drives insert, prepare, take and unused-kind requests over the input stream
// with random gaps, predicts every result with a local pool model and compares
// each result item field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module min_degree_batch_pair_pool_core_tb;
    import mdbp_pkg::*;

    localparam int DEPTH = DEF_POOL_DEPTH;

    // expected result of one request
    typedef struct {
        res_t               status;
        logic [DEG_W-1:0]   degree;
        logic [8:0]         count;
        logic [HND_W-1:0]   handle;
    } pool_result_t;

    // pool model and queue of pending results
    class pool_scoreboard;
        ent_status_t        slot_state [DEPTH];
        logic [DEG_W-1:0]   slot_degree[DEPTH];
        logic [HND_W-1:0]   slot_handle[DEPTH];
        logic [31:0]        slot_stamp [DEPTH];
        logic [31:0]        next_stamp;
        pool_result_t       awaited[$];
        int                 errors;

        function new();
            for (int i = 0; i < DEPTH; i++) begin
                slot_state[i] = ST_FREE;
            end
            next_stamp = 0;
            errors = 0;
        endfunction

        function logic [31:0] age_of(int i);
            return next_stamp - slot_stamp[i];
        endfunction

        // true when slot a is newer than slot b
        function bit is_newer(int a, int b);
            logic [31:0] aa, ab;
            aa = age_of(a);
            ab = age_of(b);
            return (aa < ab) || (aa == ab && a < b);
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // apply one accepted request and queue its result
        function void note_request(logic [1:0] kind, logic [15:0] deg, logic [15:0] hnd,
                                   logic [8:0] lim);
            pool_result_t r;
            int slot, cnt, cap, rank, pick;
            logic [15:0] mindeg;
            r.status = RES_EMPTY;
            r.degree = '0;
            r.count  = '0;
            r.handle = '0;
            if (kind == KIND_INSERT) begin
                slot = -1;
                for (int i = 0; i < DEPTH; i++) begin
                    if (slot < 0 && slot_state[i] == ST_FREE) slot = i;
                end
                if (slot < 0) begin
                    r.status = RES_FULL;
                end else begin
                    slot_state[slot]  = ST_POOL;
                    slot_degree[slot] = deg;
                    slot_handle[slot] = hnd;
                    slot_stamp[slot]  = next_stamp;
                    next_stamp        = next_stamp + 1;
                    r.status          = RES_OK;
                end
            end else if (kind == KIND_PREPARE) begin
                cnt = 0;
                mindeg = '0;
                // drop what is left of the old batch
                for (int i = 0; i < DEPTH; i++) begin
                    if (slot_state[i] == ST_BATCH) slot_state[i] = ST_FREE;
                end
                for (int i = 0; i < DEPTH; i++) begin
                    if (slot_state[i] == ST_POOL) begin
                        if (cnt == 0 || slot_degree[i] < mindeg) begin
                            mindeg = slot_degree[i];
                            cnt = 1;
                        end else if (slot_degree[i] == mindeg) begin
                            cnt++;
                        end
                    end
                end
                if (cnt > 0) begin
                    cap = cnt;
                    if (lim > 0 && lim < cap) cap = lim;
                    // move the newest pairs of the lowest degree
                    for (int i = 0; i < DEPTH; i++) begin
                        if (slot_state[i] == ST_POOL && slot_degree[i] == mindeg) begin
                            rank = 0;
                            for (int j = 0; j < DEPTH; j++) begin
                                if (j != i && slot_state[j] != ST_FREE &&
                                    slot_degree[j] == mindeg && is_newer(j, i))
                                    rank++;
                            end
                            if (rank < cap) slot_state[i] = ST_BATCH;
                        end
                    end
                    r.status = RES_OK;
                    r.degree = mindeg;
                    r.count  = (cap > 511) ? 9'd511 : 9'(cap);
                end
            end else if (kind == KIND_TAKE) begin
                pick = -1;
                for (int i = 0; i < DEPTH; i++) begin
                    if (slot_state[i] == ST_BATCH) begin
                        if (pick < 0 || is_newer(pick, i)) pick = i;
                    end
                end
                if (pick >= 0) begin
                    slot_state[pick] = ST_FREE;
                    r.status = RES_OK;
                    r.degree = slot_degree[pick];
                    r.handle = slot_handle[pick];
                end
            end
            awaited = {awaited, r};
        endfunction

        task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
            $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
            errors++;
        endtask

        task check_result(logic [1:0] st, logic [15:0] deg, logic [8:0] cnt,
                          logic [15:0] hnd);
            pool_result_t r;
            if (awaited.size() == 0) begin
                report_mismatch("unexpected item", {14'd0, st}, 16'd0);
            end else begin
                r = awaited.pop_front();
                if (st !== r.status) report_mismatch("status", {14'd0, st}, {14'd0, r.status});
                if (deg !== r.degree) report_mismatch("batch_degree", deg, r.degree);
                if (cnt !== r.count) report_mismatch("pair_count", {7'd0, cnt}, {7'd0, r.count});
                if (hnd !== r.handle) report_mismatch("out_handle", hnd, r.handle);
            end
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // pair_degree[15:0], pair_handle[31:16], batch_limit[40:32]
    logic [1:0]  s_tuser;   // kind
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // batch_degree[15:0], pair_count[24:16], out_handle[40:25]
    logic [1:0]  m_tuser;   // status

    pool_scoreboard sb;
    bit  no_gaps;
    bit  hold_req;
    bit  drive_done;
    int  sent;

    min_degree_batch_pair_pool_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // offer one item and wait for its acceptance
    task send_item(logic [1:0] kind, logic [15:0] deg, logic [15:0] hnd, logic [8:0] lim);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, lim, hnd, deg};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(kind, deg, hnd, lim);
        sent++;
    endtask

    task wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // random degree, often from a narrow set so that prepares find several pairs
    function logic [15:0] pick_degree();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
            default: return 16'($urandom_range(0, 3));
        endcase
    endfunction

    function logic [8:0] pick_limit();
        case ($urandom_range(0, 7))
            0: return 9'd0;
            1: return 9'd256;
            2: return 9'($urandom_range(0, 256));
            default: return 9'($urandom_range(1, 6));
        endcase
    endfunction

    // stimulus
    initial begin
        int n;
        sb = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        no_gaps = 1'b0;
        hold_req = 1'b0;
        drive_done = 1'b0;
        sent = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes, empty cases, tie on degree, unused kind
        send_item(KIND_TAKE, 16'h0, 16'h0, 9'd0);
        send_item(KIND_PREPARE, 16'h0, 16'h0, 9'd0);
        send_item(KIND_INSERT, 16'h0000, 16'hffff, 9'd256);
        send_item(KIND_INSERT, 16'hffff, 16'h0000, 9'd0);
        send_item(KIND_INSERT, 16'h0000, 16'h1234, 9'd1);
        send_item(KIND_PREPARE, 16'hffff, 16'hffff, 9'd0);
        send_item(KIND_TAKE, 16'h0, 16'h0, 9'd0);
        send_item(KIND_TAKE, 16'h0, 16'h0, 9'd0);
        send_item(KIND_TAKE, 16'h0, 16'h0, 9'd0);
        send_item(KIND_PREPARE, 16'h0, 16'h0, 9'd256);
        send_item(KIND_PREPARE, 16'h0, 16'h0, 9'd1);
        send_item(2'd3, 16'hffff, 16'hffff, 9'd256);
        send_item(KIND_INSERT, 16'd9, 16'ha5a5, 9'd0);
        send_item(KIND_INSERT, 16'd9, 16'h5a5a, 9'd0);
        send_item(KIND_INSERT, 16'd9, 16'h00ff, 9'd0);
        send_item(KIND_PREPARE, 16'h0, 16'h0, 9'd2);
        send_item(KIND_TAKE, 16'h0, 16'h0, 9'd0);
        send_item(KIND_INSERT, 16'd9, 16'hff00, 9'd0);
        send_item(KIND_TAKE, 16'h0, 16'h0, 9'd0);
        send_item(KIND_TAKE, 16'h0, 16'h0, 9'd0);
        send_item(KIND_PREPARE, 16'h0, 16'h0, 9'd255);

        // sender pause until everything is back
        wait_drained();

        // fill the pool past full, then take a big batch
        no_gaps = 1'b1;
        for (int i = 0; i < 260; i++) begin
            send_item(KIND_INSERT, 16'($urandom_range(4, 5)), 16'($urandom), 9'($urandom));
        end
        no_gaps = 1'b0;
        send_item(KIND_PREPARE, 16'h0, 16'h0, 9'd256);
        repeat (4) send_item(KIND_TAKE, 16'($urandom), 16'($urandom), 9'd0);
        send_item(KIND_PREPARE, 16'h0, 16'h0, 9'd0);
        send_item(KIND_PREPARE, 16'h0, 16'h0, 9'd3);

        // random insert / prepare / take sequences with some noise
        while (sent < 1170) begin
            if ($urandom_range(0, 15) == 0) no_gaps = ~no_gaps;
            if (sent > 700 && sent < 720) hold_req = 1'b1;
            n = $urandom_range(0, 4);
            repeat (n) send_item(KIND_INSERT, pick_degree(), 16'($urandom), 9'($urandom));
            if ($urandom_range(0, 9) == 0) begin
                send_item(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                          9'($urandom));
            end
            send_item(KIND_PREPARE, 16'($urandom), 16'($urandom), pick_limit());
            n = $urandom_range(0, 5);
            repeat (n) send_item(KIND_TAKE, 16'($urandom), 16'($urandom), 9'($urandom));
        end
        s_tvalid <= 1'b0;
        drive_done = 1'b1;
    end

    // receiver: random ready gaps, one long hold-off on request
    initial begin
        int gap;
        bit held;
        m_tready = 1'b0;
        held = 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (4000) @(posedge aclk);
            end
            gap = no_gaps ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            sb.check_result(m_tuser, m_tdata[15:0], m_tdata[24:16], m_tdata[40:25]);
        end
    end

    // end of run
    initial begin
        @(posedge aclk);
        while (!drive_done) @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (1200) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // timeout
    initial begin
        #40ms;
        $display("timeout with %0d results outstanding", sb.pending());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/mdbp_pkg.sv
rtl/core/mdbp_cell.sv
rtl/core/min_degree_batch_pair_pool_core.sv
tb/sv/min_degree_batch_pair_pool_core_tb.sv
